// ----- rtl/core/bucketed_hash_set_unit_macros.svh -----
// Assertion helpers for the RTL that checks itself.
`ifndef BUCKETED_HASH_SET_UNIT_MACROS_SVH
`define BUCKETED_HASH_SET_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BHS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bhs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhs assertion failed");

`endif

// ----- rtl/core/bhs_pkg.sv -----
`default_nettype none

package bhs_pkg;

    localparam int MODE_W  = 2;
    localparam int KEY_W   = 31;
    localparam int BUCKETS = 769;
    localparam int WAYS    = 4;
    localparam int ROW_W   = $clog2(BUCKETS);

    localparam int IN_TDATA_W  = ((MODE_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = RECIP_SHIFT + 1 - $clog2(BUCKETS);
    localparam int PROD_W      = KEY_W + RECIP_W;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / BUCKETS);

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_t;

    typedef slot_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic take_ready;
        logic mul;
        logic qmul;
        logic red;
        logic rd;
        logic commit;
        logic clr_wr;
    } cmd_t;

    typedef struct packed {
        logic in_take;
        logic clr_last;
        logic out_full;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/bhs_ctrl.sv -----
`default_nettype none

module bhs_ctrl
    import bhs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_QMUL  = 3'd3;
    localparam logic [2:0] ST_RED   = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_CHECK = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.take_ready = 1'b1;
                if (sts.in_take)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                cmd.qmul   = 1'b1;
                state_next = ST_RED;
            end
            ST_RED:
            begin
                cmd.red    = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!sts.out_full)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/bhs_datapath.sv -----
`default_nettype none

module bhs_datapath
    import bhs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output sts_t                        sts,
    input  wire logic                   s_axis_tvalid,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    row_t mem [BUCKETS];

    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KEY_W-1:0]  qm_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ROW_W-1:0]  clr_cnt_reg;
    row_t              rd_reg;
    row_t              wr_row;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_found_reg;
    logic              out_status_reg;

    logic [Q_W-1:0]    q;
    logic [KEY_W-1:0]  q_ext;
    logic [KEY_W-1:0]  rem;
    logic [KEY_W-1:0]  rem_sub;
    logic [WAYS-1:0]   hit;
    logic [WAYS-1:0]   free_oh;
    logic              seen_free;
    logic              found;
    logic              full;
    logic              add_drop;
    logic              mem_we;
    logic [ROW_W-1:0]  mem_waddr;
    row_t              mem_wdata;

    assign sts.in_take  = cmd.take_ready & s_axis_tvalid;
    assign sts.clr_last = (clr_cnt_reg == ROW_W'(BUCKETS - 1));
    assign sts.out_full = out_valid_reg & ~m_axis_tready;

    assign q       = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign q_ext   = KEY_W'(q);
    assign rem     = key_reg - qm_reg;
    assign rem_sub = rem - KEY_W'(BUCKETS);

    always_comb
    begin
        if (rem >= KEY_W'(BUCKETS))
        begin
            row_next = rem_sub[ROW_W-1:0];
        end
        else
        begin
            row_next = rem[ROW_W-1:0];
        end
    end

    always_comb
    begin
        seen_free = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit[w]     = rd_reg[w].valid && (rd_reg[w].key == key_reg);
            free_oh[w] = !rd_reg[w].valid && !seen_free;
            seen_free  = seen_free | !rd_reg[w].valid;
        end
    end

    assign found    = |hit;
    assign full     = !seen_free;
    assign add_drop = (mode_reg == MODE_ADD) && !found && full;

    always_comb
    begin
        wr_row = rd_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if ((mode_reg == MODE_ADD) && !found && free_oh[w])
            begin
                wr_row[w].valid = 1'b1;
                wr_row[w].key   = key_reg;
            end
            if ((mode_reg == MODE_REMOVE) && hit[w])
            begin
                wr_row[w].valid = 1'b0;
            end
        end
    end

    assign mem_we    = cmd.clr_wr | cmd.commit;
    assign mem_waddr = cmd.clr_wr ? clr_cnt_reg : row_reg;
    assign mem_wdata = cmd.clr_wr ? row_t'('0) : wr_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[row_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sts.in_take)
        begin
            mode_reg <= s_axis_tdata[MODE_W-1:0];
            key_reg  <= s_axis_tdata[MODE_W+KEY_W-1:MODE_W];
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(key_reg) * PROD_W'(RECIP);
        end
        if (cmd.qmul)
        begin
            qm_reg <= q_ext * KEY_W'(BUCKETS);
        end
        if (cmd.red)
        begin
            row_reg <= row_next;
        end
        if (cmd.commit)
        begin
            out_found_reg  <= found;
            out_status_reg <= add_drop;
        end
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_status_reg, out_found_reg};

endmodule

`default_nettype wire

// ----- rtl/core/bucketed_hash_set_unit.sv -----
// Steps, in turn: multiply by the reciprocal, multiply the quotient back, reduce to a
// row, read the row, write it; only one request is in flight. The next request is
// taken while a result still waits; the row update waits for space.
// Reset: asynchronous, active low; then a clearing pass writes all 769 rows, one per
// cycle, with s_axis_tready low until the pass ends.
`default_nettype none
`include "bucketed_hash_set_unit_macros.svh"

module bucketed_hash_set_unit
    import bhs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // mode[1:0], key[32:2], zero pad
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // found[0], status[1], zero pad
);

    cmd_t cmd;
    sts_t sts;

    bhs_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bhs_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.take_ready;

    `BHS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BHS_ASSERT_SAME(a_commit_has_room, cmd.commit, !(m_axis_tvalid && !m_axis_tready))
    `BHS_ASSERT_NEXT(a_commit_shows, cmd.commit, m_axis_tvalid)
    `BHS_ASSERT_SAME(a_cmd_exclusive, 1'b1,
        $onehot0({cmd.take_ready, cmd.mul, cmd.qmul, cmd.red, cmd.rd, cmd.commit, cmd.clr_wr}))

endmodule

`default_nettype wire

// ----- bench/bucketed_hash_set_unit_tb.sv -----
module bucketed_hash_set_unit_tb
    import bhs_pkg::*;
;

    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_MAX    = 31'h7FFF_FFFF;

    localparam int RANDOM_ITEMS   = 900;
    localparam int HOLD_AT_ITEM   = 250;
    localparam int PAUSE_AT_ITEM  = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIRECTED_N     = 23;

    typedef struct packed {
        logic found;
        logic status;
    } lookup_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic              fixed;
        logic              found;
        logic              status;
    } request_row_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic                   hold_req      = 1'b0;

    logic [KEY_W-1:0] shadow_key   [BUCKETS][WAYS];
    bit               shadow_valid [BUCKETS][WAYS];
    lookup_t          lookups_due  [$];
    int unsigned      hot_rows     [8];
    int unsigned      burst_left   = 0;
    int unsigned      fail_count   = 0;

    request_row_t directed_rows [DIRECTED_N] = '{
        '{MODE_QUERY,  31'd0,          1'b1, 1'b0, 1'b0},
        '{MODE_REMOVE, 31'd0,          1'b1, 1'b0, 1'b0},
        '{MODE_ADD,    31'd0,          1'b1, 1'b0, 1'b0},
        '{MODE_ADD,    31'd0,          1'b1, 1'b1, 1'b0},
        '{MODE_QUERY,  31'd0,          1'b1, 1'b1, 1'b0},
        '{MODE_ADD,    31'd769,        1'b1, 1'b0, 1'b0},
        '{MODE_ADD,    31'd1538,       1'b1, 1'b0, 1'b0},
        '{MODE_ADD,    31'd2307,       1'b1, 1'b0, 1'b0},
        '{MODE_ADD,    31'd3076,       1'b1, 1'b0, 1'b1},
        '{MODE_QUERY,  31'd3076,       1'b1, 1'b0, 1'b0},
        '{MODE_SPARE,  31'd769,        1'b1, 1'b1, 1'b0},
        '{MODE_REMOVE, 31'd1538,       1'b1, 1'b1, 1'b0},
        '{MODE_REMOVE, 31'd1538,       1'b1, 1'b0, 1'b0},
        '{MODE_ADD,    31'd3076,       1'b1, 1'b0, 1'b0},
        '{MODE_ADD,    KEY_MAX,        1'b1, 1'b0, 1'b0},
        '{MODE_QUERY,  KEY_MAX,        1'b1, 1'b1, 1'b0},
        '{MODE_SPARE,  KEY_MAX,        1'b1, 1'b1, 1'b0},
        '{MODE_REMOVE, KEY_MAX,        1'b1, 1'b1, 1'b0},
        '{MODE_QUERY,  KEY_MAX,        1'b1, 1'b0, 1'b0},
        '{MODE_ADD,    31'h5555_5555,  1'b0, 1'b0, 1'b0},
        '{MODE_ADD,    31'h2AAA_AAAA,  1'b0, 1'b0, 1'b0},
        '{MODE_SPARE,  31'h2AAA_AAAA,  1'b0, 1'b0, 1'b0},
        '{MODE_ADD,    31'd768,        1'b1, 1'b0, 1'b0}
    };

    bucketed_hash_set_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic lookup_t apply_request(input logic [MODE_W-1:0] mode,
                                              input logic [KEY_W-1:0] key);
        int unsigned row;
        int          hit;
        int          spare;
        lookup_t     res;
        row   = 32'(key) % BUCKETS;
        hit   = -1;
        spare = -1;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (shadow_valid[row][w] && shadow_key[row][w] == key)
                hit = w;
            if (!shadow_valid[row][w])
                spare = w;
        end
        res.found  = (hit >= 0);
        res.status = 1'b0;
        if (mode == MODE_ADD && hit < 0)
        begin
            if (spare >= 0)
            begin
                shadow_key[row][spare]   = key;
                shadow_valid[row][spare] = 1'b1;
            end
            else
                res.status = 1'b1;
        end
        else if (mode == MODE_REMOVE && hit >= 0)
            shadow_valid[row][hit] = 1'b0;
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        int unsigned row;
        int unsigned span;
        sel = $urandom_range(0, 99);
        row = hot_rows[$urandom_range(0, 7)];
        if (sel < 15)
            return KEY_W'($urandom());
        if (sel < 85)
            return KEY_W'(row + BUCKETS * $urandom_range(0, 7));
        span = (32'(KEY_MAX) - row) / BUCKETS;
        return KEY_W'(row + BUCKETS * $urandom_range(0, span));
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return MODE_ADD;
        if (sel < 70)
            return MODE_REMOVE;
        if (sel < 95)
            return MODE_QUERY;
        return MODE_SPARE;
    endfunction

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                                input logic fixed, input logic want_found,
                                input logic want_status);
        lookup_t due;
        s_axis_tdata  <= IN_TDATA_W'({key, mode});
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        due = apply_request(mode, key);
        if (fixed)
            due = '{found: want_found, status: want_status};
        lookups_due = {lookups_due, due};
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (lookups_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        hot_rows[0] = 0;
        hot_rows[1] = BUCKETS - 1;
        for (int i = 2; i < 8; i++)
            hot_rows[i] = $urandom_range(0, BUCKETS - 1);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_N; i++)
        begin
            pace_sender();
            send_request(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].fixed,
                         directed_rows[i].found, directed_rows[i].status);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_AT_ITEM)
            begin
                hold_req   <= 1'b1;
                burst_left = 60;
            end
            if (i == PAUSE_AT_ITEM)
                wait_drained();
            pace_sender();
            send_request(pick_mode(), pick_key(), 1'b0, 1'b0, 1'b0);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned style;
        int unsigned span;
        bit          held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 80);
            for (int k = 0; k < span; k++)
            begin
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (k % 3 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        lookup_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (lookups_due.size() == 0)
            begin
                $error("result word with no request pending: tdata %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = lookups_due.pop_front();
                if (m_axis_tdata[0] !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[1] !== want.status)
                begin
                    $error("status: expected %0b, got %0b", want.status, m_axis_tdata[1]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
